### design/text_cell_glyph_renderer_top_defines.svh
// assertion macros used by the text cell glyph renderer top level
`ifndef TEXT_CELL_GLYPH_RENDERER_TOP_DEFINES_SVH
`define TEXT_CELL_GLYPH_RENDERER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, off while reset is low
`define TCGR_ASSERT(name, clk, rstn, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// checked property that must hold through reset too
`define TCGR_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TCGR_ASSERT(name, clk, rstn, prop, msg)
`define TCGR_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

### design/tcgr_pkg.sv
// types, constants and the colour palette of the text cell glyph renderer
`timescale 1ns / 1ps
`default_nettype none
package tcgr_pkg;

	localparam int unsigned COLUMNS_DEF      = 80;
	localparam int unsigned ROWS_DEF         = 25;
	localparam int unsigned GLYPH_HEIGHT_DEF = 22;

	localparam int unsigned GLYPH_WIDTH     = 12;
	localparam int unsigned GLYPH_COUNT     = 256;
	localparam int unsigned BYTES_PER_PIXEL = 2;
	localparam int unsigned HALF_PIXELS     = 6;
	localparam int unsigned HALF_BYTES      = HALF_PIXELS * BYTES_PER_PIXEL;

	localparam int unsigned CFG_INDEX_W  = 3;
	localparam int unsigned CFG_DATA_W   = 32;
	localparam int unsigned LP_W         = 13;
	localparam int unsigned MARGIN_W     = 12;
	// column * glyph width + left margin stays below 2^13
	localparam int unsigned X_W          = 13;

	localparam logic [31:0]         FRAME_BASE_RST  = 32'd0;
	localparam logic [LP_W-1:0]     LINE_PIXELS_RST = 13'd1200;
	localparam logic [MARGIN_W-1:0] MARGIN_TOP_RST  = 12'd175;
	localparam logic [MARGIN_W-1:0] MARGIN_LEFT_RST = 12'd120;
	localparam logic [7:0]          FIRST_CODE_RST  = 8'd0;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_BASE,
		REG_LINE_PIXELS,
		REG_MARGIN_TOP,
		REG_MARGIN_LEFT,
		REG_FIRST_CODE
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMD_CHAR,
		CMD_COLOR,
		CMD_BOTH,
		CMD_FONT
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MERGE,
		ST_ADDR,
		ST_RENDER
	} state_t;

	typedef struct packed {
		logic load;
		logic half;
		logic last;
	} out_ctl_t;

	function automatic logic [15:0] palette(input logic [3:0] idx);
		logic [15:0] c;
		case (idx)
			4'd0:    c = 16'h0000;
			4'd1:    c = 16'h0015;
			4'd2:    c = 16'h0540;
			4'd3:    c = 16'h0555;
			4'd4:    c = 16'ha800;
			4'd5:    c = 16'ha815;
			4'd6:    c = 16'haab5;
			4'd7:    c = 16'had55;
			4'd8:    c = 16'h52aa;
			4'd9:    c = 16'h52bf;
			4'd10:   c = 16'h57ea;
			4'd11:   c = 16'h57ff;
			4'd12:   c = 16'hfaaa;
			4'd13:   c = 16'hfabf;
			4'd14:   c = 16'hffea;
			4'd15:   c = 16'hffff;
			default: c = 16'h0000;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

### design/tcgr_ifs.sv
// command and pixel channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface tcgr_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [4:0]  cell_row;
	logic [6:0]  cell_column;
	logic [7:0]  char_code;
	logic [7:0]  attribute;
	logic [12:0] font_row_index;
	logic [15:0] font_row_bits;

	modport source (
		output valid, command, cell_row, cell_column, char_code, attribute,
			font_row_index, font_row_bits,
		input  ready
	);
	modport sink (
		input  valid, command, cell_row, cell_column, char_code, attribute,
			font_row_index, font_row_bits,
		output ready
	);
endinterface

interface tcgr_pix_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_address;
	logic [15:0] pixel_a;
	logic [15:0] pixel_b;
	logic [15:0] pixel_c;
	logic [15:0] pixel_d;
	logic [15:0] pixel_e;
	logic [15:0] pixel_f;
	logic        last;

	modport source (
		output valid, pixel_address, pixel_a, pixel_b, pixel_c, pixel_d, pixel_e,
			pixel_f, last,
		input  ready
	);
	modport sink (
		input  valid, pixel_address, pixel_a, pixel_b, pixel_c, pixel_d, pixel_e,
			pixel_f, last,
		output ready
	);
endinterface
`default_nettype wire

### design/tcgr_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module tcgr_ram #(
	parameter int unsigned WIDTH  = 16,
	parameter int unsigned DEPTH  = 2000,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds until the next read
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### design/tcgr_out_stage.sv
// output register: picks one half glyph row and colours six pixels
`timescale 1ns / 1ps
`default_nettype none
module tcgr_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tcgr_pkg::out_ctl_t ctl,
	input  wire logic [15:0]       bits,
	input  wire logic [15:0]       fg,
	input  wire logic [15:0]       bg,
	input  wire logic [31:0]       row_addr,
	output logic                   free,
	tcgr_pix_if.source             pix
);
	import tcgr_pkg::*;

	logic        valid_q;
	logic [5:0]  sel;
	logic [31:0] addr_q;
	logic [15:0] px_q [HALF_PIXELS];
	logic        last_q;

	// left half uses bits 15..10, right half bits 9..4
	assign sel  = ctl.half ? bits[9:4] : bits[15:10];
	assign free = !valid_q || pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= 1'b1;
		end else if (pix.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			addr_q <= ctl.half ? row_addr + 32'(HALF_BYTES) : row_addr;
			last_q <= ctl.last;
			for (int p = 0; p < HALF_PIXELS; p++) begin
				px_q[p] <= sel[HALF_PIXELS-1-p] ? fg : bg;
			end
		end
	end

	assign pix.valid         = valid_q;
	assign pix.pixel_address = addr_q;
	assign pix.pixel_a       = px_q[0];
	assign pix.pixel_b       = px_q[1];
	assign pix.pixel_c       = px_q[2];
	assign pix.pixel_d       = px_q[3];
	assign pix.pixel_e       = px_q[4];
	assign pix.pixel_f       = px_q[5];
	assign pix.last          = last_q;

endmodule
`default_nettype wire

### design/text_cell_glyph_renderer_top.sv
// top level of the text cell glyph renderer
`timescale 1ns / 1ps
`default_nettype none
`include "text_cell_glyph_renderer_top_defines.svh"
// Text cell glyph renderer. After reset the cell store is cleared one cell per
// cycle before the first command is taken; configuration writes are taken
// throughout. A cell write that falls inside the text window reads, merges and
// writes back the cell and forms the start address, then gives 2*GLYPH_HEIGHT
// half-row transfers (44 by default), one per cycle while the pixel sink keeps
// up: each glyph row costs one font store read and two loads of the output
// register. A cell write outside the window is dropped. The next command is
// taken as soon as the last half row sits in the output register.
module text_cell_glyph_renderer_top #(
	parameter int unsigned COLUMNS      = tcgr_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS         = tcgr_pkg::ROWS_DEF,
	parameter int unsigned GLYPH_HEIGHT = tcgr_pkg::GLYPH_HEIGHT_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	tcgr_cmd_if.sink                            cmd,
	tcgr_pix_if.source                          pix,
	input  wire logic                           cfg_we,
	input  wire logic [tcgr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [tcgr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import tcgr_pkg::*;

	localparam int unsigned CELLS      = ROWS * COLUMNS;
	localparam int unsigned CELL_AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int unsigned FONT_DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
	localparam int unsigned FONT_AW    = $clog2(FONT_DEPTH);
	localparam int unsigned RW         = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
	// highest cell row the port can carry is 31
	localparam int unsigned LINE_W     = $clog2(31 * GLYPH_HEIGHT + 4096);
	localparam int unsigned PROD_W     = LINE_W + LP_W;

	// configuration
	logic [31:0]         frame_base_q;
	logic [LP_W-1:0]     line_pixels_q;
	logic [MARGIN_W-1:0] margin_top_q;
	logic [MARGIN_W-1:0] margin_left_q;
	logic [7:0]          first_code_q;

	state_t state_q, state_d;

	logic [CELL_AW-1:0] clr_q;
	cmd_t               cmd_q;
	logic [7:0]         ch_q;
	logic [7:0]         attr_q;
	logic [CELL_AW-1:0] cell_q;
	logic [LINE_W-1:0]  line0_q;
	logic [X_W-1:0]     x0_q;
	logic [PROD_W-1:0]  prod_q;
	logic [15:0]        fg_q;
	logic [15:0]        bg_q;
	logic [FONT_AW-1:0] font_addr_q;
	logic [RW-1:0]      r_q;
	logic               half_q;
	logic [31:0]        row_addr_q;

	logic               acc;
	cmd_t               in_cmd;
	logic               in_range;
	logic               font_ok;
	logic [CELL_AW-1:0] in_cell;
	logic               last_row;
	logic [PROD_W:0]    pos_sum;

	logic               cell_we;
	logic [CELL_AW-1:0] cell_waddr;
	logic [15:0]        cell_wdata;
	logic               cell_re;
	logic [15:0]        cell_rdata;
	logic [7:0]         new_ch;
	logic [7:0]         new_col;
	logic [7:0]         glyph;

	logic               font_we;
	logic               font_re;
	logic [FONT_AW-1:0] font_raddr;
	logic [15:0]        font_rdata;

	out_ctl_t           out_ctl;
	logic               out_free;

	assign acc      = cmd.valid && cmd.ready;
	assign in_cmd   = cmd_t'(cmd.command);
	assign in_range = (32'(cmd.cell_row) < 32'(ROWS)) &&
		(32'(cmd.cell_column) < 32'(COLUMNS));
	assign font_ok  = 32'(cmd.font_row_index) < 32'(FONT_DEPTH);
	assign in_cell  = CELL_AW'(32'(cmd.cell_row) * COLUMNS + 32'(cmd.cell_column));
	assign last_row = r_q == RW'(GLYPH_HEIGHT - 1);
	assign pos_sum  = {1'b0, prod_q} + (PROD_W + 1)'(x0_q);

	// merge of the stored cell with the command
	assign new_ch  = (cmd_q == CMD_CHAR || cmd_q == CMD_BOTH) ? ch_q : cell_rdata[15:8];
	assign new_col = (cmd_q == CMD_COLOR || cmd_q == CMD_BOTH) ? attr_q : cell_rdata[7:0];
	assign glyph   = new_ch - first_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q  <= FRAME_BASE_RST;
			line_pixels_q <= LINE_PIXELS_RST;
			margin_top_q  <= MARGIN_TOP_RST;
			margin_left_q <= MARGIN_LEFT_RST;
			first_code_q  <= FIRST_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_BASE:  frame_base_q  <= cfg_wdata;
				REG_LINE_PIXELS: line_pixels_q <= cfg_wdata[LP_W-1:0];
				REG_MARGIN_TOP:  margin_top_q  <= cfg_wdata[MARGIN_W-1:0];
				REG_MARGIN_LEFT: margin_left_q <= cfg_wdata[MARGIN_W-1:0];
				REG_FIRST_CODE:  first_code_q  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CELL_AW'(CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc && in_cmd != CMD_FONT && in_range) begin
					state_d = ST_MERGE;
				end
			end
			ST_MERGE:  state_d = ST_ADDR;
			ST_ADDR:   state_d = ST_RENDER;
			ST_RENDER: begin
				if (out_free && half_q && last_row) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_CLEAR;
		endcase
	end

	// memory and output controls
	always_comb begin
		cmd.ready    = 1'b0;
		cell_we      = 1'b0;
		cell_waddr   = cell_q;
		cell_wdata   = {new_ch, new_col};
		cell_re      = 1'b0;
		font_we      = 1'b0;
		font_re      = 1'b0;
		font_raddr   = font_addr_q;
		out_ctl.load = 1'b0;
		out_ctl.half = half_q;
		out_ctl.last = half_q && last_row;
		case (state_q)
			ST_CLEAR: begin
				cell_we    = 1'b1;
				cell_waddr = clr_q;
				cell_wdata = 16'h0000;
			end
			ST_IDLE: begin
				cmd.ready = 1'b1;
				cell_re   = acc && in_cmd != CMD_FONT && in_range;
				font_we   = acc && in_cmd == CMD_FONT && font_ok;
			end
			ST_MERGE: begin
				cell_we = 1'b1;
			end
			ST_ADDR: begin
				font_re = 1'b1;
			end
			ST_RENDER: begin
				out_ctl.load = out_free;
				// fetch the next glyph row as the right half leaves
				font_re      = out_free && half_q && !last_row;
				font_raddr   = font_addr_q + FONT_AW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			r_q     <= '0;
			half_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CELL_AW'(1);
			end
			if (state_q == ST_ADDR) begin
				r_q    <= '0;
				half_q <= 1'b0;
			end else if (state_q == ST_RENDER && out_free) begin
				half_q <= !half_q;
				if (half_q) begin
					r_q <= r_q + RW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q   <= in_cmd;
			ch_q    <= cmd.char_code;
			attr_q  <= cmd.attribute;
			cell_q  <= in_cell;
			line0_q <= LINE_W'(32'(cmd.cell_row) * GLYPH_HEIGHT + 32'(margin_top_q));
			x0_q    <= X_W'(32'(cmd.cell_column) * GLYPH_WIDTH + 32'(margin_left_q));
		end
		if (state_q == ST_MERGE) begin
			font_addr_q <= FONT_AW'(32'(glyph) * GLYPH_HEIGHT);
			fg_q        <= palette(new_col[3:0]);
			bg_q        <= palette({1'b0, new_col[6:4]});
			prod_q      <= PROD_W'(line0_q) * PROD_W'(line_pixels_q);
		end
		if (state_q == ST_ADDR) begin
			row_addr_q <= frame_base_q + 32'({pos_sum, 1'b0});
		end else if (state_q == ST_RENDER && out_free && half_q) begin
			row_addr_q  <= row_addr_q + 32'({line_pixels_q, 1'b0});
			font_addr_q <= font_addr_q + FONT_AW'(1);
		end
	end

	tcgr_ram #(
		.WIDTH (16),
		.DEPTH (CELLS)
	) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.re    (cell_re),
		.raddr (in_cell),
		.rdata (cell_rdata)
	);

	tcgr_ram #(
		.WIDTH (16),
		.DEPTH (FONT_DEPTH)
	) u_font_ram (
		.clk   (clk),
		.we    (font_we),
		.waddr (FONT_AW'(cmd.font_row_index)),
		.wdata (cmd.font_row_bits),
		.re    (font_re),
		.raddr (font_raddr),
		.rdata (font_rdata)
	);

	tcgr_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (out_ctl),
		.bits     (font_rdata),
		.fg       (fg_q),
		.bg       (bg_q),
		.row_addr (row_addr_q),
		.free     (out_free),
		.pix      (pix)
	);

	`TCGR_ASSERT(a_no_accept_while_rendering, clk, arst_n, (cmd.valid && cmd.ready) |-> !out_ctl.load, "command taken while rendering")
	`TCGR_ASSERT(a_merge_follows_accept, clk, arst_n, (state_q == ST_MERGE) |-> $past(cmd.valid && cmd.ready), "cell merge without a command")
	`TCGR_ASSERT(a_last_ends_render, clk, arst_n, (out_ctl.load && out_ctl.last) |=> (state_q == ST_IDLE), "render did not end after last half row")
	`TCGR_ASSERT_ALWAYS(a_no_ready_in_reset, clk, !arst_n |-> !cmd.ready, "ready high during reset")

endmodule
`default_nettype wire
